[src/tdpf_pkg.sv]
// Shared types and constants for the touch debounce and point filter.
`default_nettype none
package tdpf_pkg;
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_ACQUIRE  = 3'd2,
    PH_TOUCHED  = 3'd3,
    PH_HOLD     = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    CFG_MARGIN   = 3'd0,
    CFG_DEBOUNCE = 3'd1,
    CFG_RELAX    = 3'd2,
    CFG_HOLD     = 3'd3,
    CFG_RELAX_EX = 3'd4,
    CFG_TRACK_EX = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned ScanN       = 5;

  // Back-end job kinds
  typedef enum logic [1:0] {
    JOB_NONE  = 2'd0,
    JOB_STORE = 2'd1,
    JOB_CHECK = 2'd2
  } job_e;
endpackage
`default_nettype wire

[src/touch_debounce_and_point_filter_unit.sv]
// Top level of the touch debounce and point filter.
// A scan is registered in the front end and then in the back-end phase registers; a scan that
// fills the window also waits for the in-place odd-even transposition sort of the window.
// Throughput: one scan per cycle while results are popped and no window sort is running.
// Reset: asynchronous active low; phase idle, counts and held point zero,
// registers at their defaults; the window store is not cleared.
`default_nettype none
module touch_debounce_and_point_filter_unit
  import tdpf_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 8,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic                     pen_down_i,
  input  wire logic [31:0]              now_tick_i,
  input  wire logic [SAMPLE_BITS-1:0]   x_raw_a_i,
  input  wire logic [SAMPLE_BITS-1:0]   x_raw_b_i,
  input  wire logic [SAMPLE_BITS-1:0]   x_raw_c_i,
  input  wire logic [SAMPLE_BITS-1:0]   x_raw_d_i,
  input  wire logic [SAMPLE_BITS-1:0]   x_raw_e_i,
  input  wire logic [SAMPLE_BITS-1:0]   y_raw_a_i,
  input  wire logic [SAMPLE_BITS-1:0]   y_raw_b_i,
  input  wire logic [SAMPLE_BITS-1:0]   y_raw_c_i,
  input  wire logic [SAMPLE_BITS-1:0]   y_raw_d_i,
  input  wire logic [SAMPLE_BITS-1:0]   y_raw_e_i,
  output logic                          empty,
  input  wire logic                     pop,
  output logic                          touch_valid_o,
  output logic [11:0]                   point_x_o,
  output logic [11:0]                   point_y_o,
  output logic [2:0]                    phase_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]    cfg_idx_i,
  input  wire logic [CfgDataBits-1:0]   cfg_data_i
);
  logic [7:0]  margin_q, relax_ex_q, track_ex_q;
  logic [15:0] debounce_q, relax_q, hold_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q   <= 8'd20;
      debounce_q <= 16'd30;
      relax_q    <= 16'd60;
      hold_q     <= 16'd40;
      relax_ex_q <= 8'd15;
      track_ex_q <= 8'd60;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MARGIN:   margin_q   <= cfg_data_i[7:0];
        CFG_DEBOUNCE: debounce_q <= cfg_data_i;
        CFG_RELAX:    relax_q    <= cfg_data_i;
        CFG_HOLD:     hold_q     <= cfg_data_i;
        CFG_RELAX_EX: relax_ex_q <= cfg_data_i[7:0];
        CFG_TRACK_EX: track_ex_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [SAMPLE_BITS-1:0] xr [ScanN];
  logic [SAMPLE_BITS-1:0] yr [ScanN];
  assign xr = '{x_raw_a_i, x_raw_b_i, x_raw_c_i, x_raw_d_i, x_raw_e_i};
  assign yr = '{y_raw_a_i, y_raw_b_i, y_raw_c_i, y_raw_d_i, y_raw_e_i};

  logic                   f_ready, f_valid, f_pen, b_ready, b_valid;
  logic [31:0]            f_tick;
  logic [SAMPLE_BITS-1:0] f_x, f_y;

  tdpf_front #(.SampleBits(SAMPLE_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(push), .in_ready_o(f_ready),
    .pen_i(pen_down_i), .tick_i(now_tick_i), .xr_i(xr), .yr_i(yr),
    .out_valid_o(f_valid), .out_ready_i(b_ready),
    .pen_o(f_pen), .tick_o(f_tick), .x_o(f_x), .y_o(f_y)
  );

  tdpf_back #(.WindowDepth(WINDOW_DEPTH), .SampleBits(SAMPLE_BITS)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(b_ready),
    .pen_i(f_pen), .tick_i(f_tick), .x_i(f_x), .y_i(f_y),
    .margin_i(margin_q), .debounce_i(debounce_q), .relax_i(relax_q), .hold_i(hold_q),
    .relax_ex_i(relax_ex_q), .track_ex_i(track_ex_q),
    .out_valid_o(b_valid), .out_ready_i(pop),
    .touch_o(touch_valid_o), .px_o(point_x_o), .py_o(point_y_o), .phase_o(phase_o)
  );

  assign full  = !f_ready;
  assign empty = !b_valid;

  // a touch report always leaves in the touched or hold phase
  a_touch_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && touch_valid_o) |-> (phase_o == PH_TOUCHED || phase_o == PH_HOLD))
    else $error("touch reported in wrong phase");
  // a result held while not popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(point_x_o) && $stable(touch_valid_o)))
    else $error("result changed while waiting");
  // idle phase never reports
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && phase_o == PH_IDLE) |-> !touch_valid_o)
    else $error("touch in idle");
endmodule
`default_nettype wire

[src/tdpf_front.sv]
// Front end: reduces five raw conversions per axis to one point (min/max trim + mid-3 average).
`default_nettype none
module tdpf_front
  import tdpf_pkg::*;
#(
  parameter int unsigned SampleBits = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  pen_i,
  input  wire logic [31:0]           tick_i,
  input  wire logic [SampleBits-1:0] xr_i [ScanN],
  input  wire logic [SampleBits-1:0] yr_i [ScanN],
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       pen_o,
  output logic [31:0]                tick_o,
  output logic [SampleBits-1:0]      x_o,
  output logic [SampleBits-1:0]      y_o
);
  localparam int unsigned SumBits = SampleBits + 2;
  localparam int unsigned ProdBits = SumBits + 18;

  logic                  valid_q;
  logic                  pen_q;
  logic [31:0]           tick_q;
  logic [SumBits-1:0]    sx_q, sy_q;

  // sum of middle three = total - min - max
  function automatic logic [SumBits-1:0] mid3(input logic [SampleBits-1:0] v [ScanN]);
    logic [SampleBits-1:0] mn, mx;
    logic [SumBits+1:0]    tot;
    mn = v[0];
    mx = v[0];
    tot = '0;
    for (int i = 0; i < ScanN; i++) begin
      if (v[i] < mn) mn = v[i];
      if (v[i] > mx) mx = v[i];
      tot = tot + (SumBits+2)'(v[i]);
    end
    tot = tot - (SumBits+2)'(mn) - (SumBits+2)'(mx);
    return tot[SumBits-1:0];
  endfunction

  // x / 3 as a multiply by ceil(2^19 / 3) and a shift; exact for x below 2^19
  function automatic logic [SampleBits-1:0] div3(input logic [SumBits-1:0] s);
    logic [ProdBits-1:0] p;
    p = ProdBits'(s) * ProdBits'(18'h2AAAB);
    return SampleBits'(p >> 19);
  endfunction

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pen_q  <= pen_i;
      tick_q <= tick_i;
      sx_q   <= mid3(xr_i);
      sy_q   <= mid3(yr_i);
    end
  end

  // divide by 3 of the registered sum
  assign out_valid_o = valid_q;
  assign pen_o       = pen_q;
  assign tick_o      = tick_q;
  assign x_o         = div3(sx_q);
  assign y_o         = div3(sy_q);
endmodule
`default_nettype wire

[src/tdpf_back.sv]
// Back end: phase controller, point window, and sequential sort of a full window.
`default_nettype none
module tdpf_back
  import tdpf_pkg::*;
#(
  parameter int unsigned WindowDepth = 8,
  parameter int unsigned SampleBits  = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  pen_i,
  input  wire logic [31:0]           tick_i,
  input  wire logic [SampleBits-1:0] x_i,
  input  wire logic [SampleBits-1:0] y_i,
  input  wire logic [7:0]            margin_i,
  input  wire logic [15:0]           debounce_i,
  input  wire logic [15:0]           relax_i,
  input  wire logic [15:0]           hold_i,
  input  wire logic [7:0]            relax_ex_i,
  input  wire logic [7:0]            track_ex_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       touch_o,
  output logic [11:0]                px_o,
  output logic [11:0]                py_o,
  output logic [2:0]                 phase_o
);
  localparam int unsigned IdxBits = $clog2(WindowDepth);
  localparam int unsigned CntBits = $clog2(WindowDepth + 1);
  localparam int unsigned PassBits = $clog2(WindowDepth + 1);

  phase_e                 phase_q, phase_d;
  logic [CntBits-1:0]     fill_q, fill_d;
  logic [31:0]            mark_q, mark_d;
  logic [SampleBits-1:0]  hx_q, hx_d, hy_q, hy_d;
  logic [SampleBits-1:0]  xw_q [WindowDepth];
  logic [SampleBits-1:0]  yw_q [WindowDepth];
  logic                   busy_q, busy_d;
  logic [PassBits-1:0]    pass_q, pass_d;
  logic                   relax_ok_q, relax_ok_d;
  logic [31:0]            tick_q, tick_d;
  logic                   ov_q, ov_d;
  logic                   tv_q, tv_d;
  logic                   wr_en;
  logic [IdxBits-1:0]     wr_idx;
  logic                   sort_step;

  logic [31:0]   elapsed;
  logic          take;
  logic [CntBits-1:0] fidx;
  logic [SampleBits:0] sx, sy, lim_a, lim_r, lim_t;
  logic          pass_ok;

  assign in_ready_o = !busy_q && (!ov_q || out_ready_i);
  assign take       = in_valid_i && in_ready_o;
  assign elapsed    = tick_i - mark_q;
  assign fidx       = (fill_q >= CntBits'(WindowDepth)) ? '0 : fill_q;
  assign wr_idx     = IdxBits'(fidx);

  assign sx    = {1'b0, xw_q[WindowDepth-1]} - {1'b0, xw_q[0]};
  assign sy    = {1'b0, yw_q[WindowDepth-1]} - {1'b0, yw_q[0]};
  assign lim_a = (SampleBits+1)'(margin_i);
  assign lim_r = (SampleBits+1)'({1'b0, margin_i} + {1'b0, relax_ex_i});
  assign lim_t = (SampleBits+1)'({1'b0, margin_i} + {1'b0, track_ex_i});
  always_comb begin
    if (phase_q == PH_ACQUIRE) begin
      pass_ok = (sx < lim_a && sy < lim_a) || (relax_ok_q && sx < lim_r && sy < lim_r);
    end else begin
      pass_ok = sx < lim_t && sy < lim_t;
    end
  end

  // phase control
  always_comb begin
    phase_d    = phase_q;
    fill_d     = fill_q;
    mark_d     = mark_q;
    hx_d       = hx_q;
    hy_d       = hy_q;
    busy_d     = busy_q;
    pass_d     = pass_q;
    relax_ok_d = relax_ok_q;
    tick_d     = tick_q;
    ov_d       = ov_q && !out_ready_i;
    tv_d       = tv_q;
    wr_en      = 1'b0;
    sort_step  = 1'b0;
    if (busy_q) begin
      if (pass_q != '0) begin
        sort_step = 1'b1;
        pass_d    = pass_q - 1'b1;
      end else begin
        busy_d = 1'b0;
        ov_d   = 1'b1;
        tv_d   = pass_ok;
        if (pass_ok) begin
          hx_d = xw_q[WindowDepth/2];
          hy_d = yw_q[WindowDepth/2];
          if (phase_q == PH_ACQUIRE) begin
            phase_d = PH_TOUCHED;
            mark_d  = tick_q;
          end else begin
            phase_d = PH_HOLD;
          end
        end
      end
    end else if (take) begin
      ov_d = 1'b1;
      tv_d = 1'b0;
      if (phase_q != PH_IDLE && !pen_i) begin
        phase_d = PH_IDLE;
        fill_d  = '0;
      end else begin
        case (phase_q)
          PH_IDLE: begin
            if (pen_i) begin
              phase_d = PH_DEBOUNCE;
              mark_d  = tick_i;
            end
          end
          PH_DEBOUNCE: begin
            if (elapsed > 32'(debounce_i)) begin
              phase_d = PH_ACQUIRE;
              mark_d  = tick_i;
            end
          end
          PH_ACQUIRE, PH_TOUCHED: begin
            wr_en = 1'b1;
            if (fidx == CntBits'(WindowDepth - 1)) begin
              fill_d     = '0;
              busy_d     = 1'b1;
              ov_d       = 1'b0;
              pass_d     = PassBits'(WindowDepth);
              relax_ok_d = elapsed > 32'(relax_i);
              tick_d     = tick_i;
            end else begin
              fill_d = fidx + 1'b1;
            end
          end
          PH_HOLD: begin
            if (elapsed > 32'(hold_i)) begin
              phase_d = PH_TOUCHED;
              fill_d  = '0;
              mark_d  = tick_i;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            fill_d  = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      fill_q  <= '0;
      mark_q  <= '0;
      hx_q    <= '0;
      hy_q    <= '0;
      busy_q  <= 1'b0;
      pass_q  <= '0;
      ov_q    <= 1'b0;
      tv_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
      mark_q  <= mark_d;
      hx_q    <= hx_d;
      hy_q    <= hy_d;
      busy_q  <= busy_d;
      pass_q  <= pass_d;
      ov_q    <= ov_d;
      tv_q    <= tv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    relax_ok_q <= relax_ok_d;
    tick_q     <= tick_d;
  end

  // window store; odd-even transposition sort, one pass per cycle, in place
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      xw_q[wr_idx] <= x_i;
      yw_q[wr_idx] <= y_i;
    end else if (sort_step) begin
      for (int i = 0; i + 1 < int'(WindowDepth); i++) begin
        if (i[0] == pass_q[0]) begin
          if (xw_q[i] > xw_q[i+1]) begin
            xw_q[i]   <= xw_q[i+1];
            xw_q[i+1] <= xw_q[i];
          end
          if (yw_q[i] > yw_q[i+1]) begin
            yw_q[i]   <= yw_q[i+1];
            yw_q[i+1] <= yw_q[i];
          end
        end
      end
    end
  end

  assign out_valid_o = ov_q;
  assign touch_o     = tv_q;
  assign px_o        = 12'(hx_q);
  assign py_o        = 12'(hy_q);
  assign phase_o     = phase_q;
endmodule
`default_nettype wire
